// File: rtl/cst_pkg.sv
// Package: shared types and constants of the CSV stream tokenizer.
package cst_pkg;

   localparam int FIELD_LIMIT = 4096;
   localparam int LEN_W       = $clog2(FIELD_LIMIT);
   localparam int FPOS_W      = 10;
   localparam int RPOS_W      = 24;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_HT    = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] DELIM_RESET = 8'd44;

   localparam logic [FPOS_W-1:0] FPOS_MAX = '1;
   localparam logic [RPOS_W-1:0] RPOS_MAX = '1;

   typedef enum logic [2:0] {
      KIND_BYTE = 3'd0,
      KIND_FEND = 3'd1,
      KIND_REND = 3'd2,
      KIND_OVF  = 3'd3,
      KIND_DOC  = 3'd4
   } kind_type;

   // One queued result; a document end may carry a row end in front of it.
   typedef struct packed {
      kind_type          kind;
      logic [7:0]        field_byte;
      logic [FPOS_W-1:0] fpos;
      logic [RPOS_W-1:0] rpos;
      logic              pre_rend;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: rtl/cst_front.sv
// Front end: accepts text items, classifies bytes and tracks parser state.
module cst_front import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_func,
   input  logic [7:0]   req_text_byte,
   input  logic         csr_valid,
   input  logic [7:0]   csr_delimiter_char,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_entry
);

   logic [7:0]        delim_ff, delim_in;
   logic              iq_ff, iq_in;
   logic              qp_ff, qp_in;
   logic              crp_ff, crp_in;
   logic              fb_ff, fb_in;
   logic              rhf_ff, rhf_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [FPOS_W-1:0] fcnt_ff, fcnt_in;
   logic [RPOS_W-1:0] rcnt_ff, rcnt_in;
   logic              err_ff, err_in;

   logic accept;
   logic is_q, is_delim, is_nl, is_ws, swallow;
   logic do_unq, do_qemit;
   logic u_quote, u_delim, u_nl, u_emit, emit, ovf;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   assign is_q     = (req_text_byte == CHAR_QUOTE);
   assign is_delim = (req_text_byte == delim_ff);
   assign is_nl    = (req_text_byte == CHAR_LF) || (req_text_byte == CHAR_CR);
   assign is_ws    = (req_text_byte == CHAR_SP) || (req_text_byte == CHAR_HT) ||
                     (req_text_byte == CHAR_VT) || (req_text_byte == CHAR_FF);
   assign swallow  = crp_ff && (req_text_byte == CHAR_LF);

   assign do_unq   = !swallow && (qp_ff ? !is_q : !iq_ff);
   assign do_qemit = !swallow && (qp_ff ? is_q : (iq_ff && !is_q));

   // quote wins over delimiter, delimiter wins over CR/LF
   assign u_quote = do_unq && is_q;
   assign u_delim = do_unq && !is_q && is_delim;
   assign u_nl    = do_unq && !is_q && !is_delim && is_nl;
   assign u_emit  = do_unq && !is_q && !is_delim && !is_nl && !(is_ws && !fb_ff);
   assign emit    = do_qemit || u_emit;
   assign ovf     = (len_ff >= LEN_W'(FIELD_LIMIT - 1));

   always_comb begin
      delim_in = delim_ff;
      iq_in    = iq_ff;
      qp_in    = qp_ff;
      crp_in   = crp_ff;
      fb_in    = fb_ff;
      rhf_in   = rhf_ff;
      len_in   = len_ff;
      fcnt_in  = fcnt_ff;
      rcnt_in  = rcnt_ff;
      err_in   = err_ff;
      push     = 1'b0;
      push_entry.kind       = KIND_BYTE;
      push_entry.field_byte = 8'd0;
      push_entry.fpos       = fcnt_ff;
      push_entry.rpos       = rcnt_ff;
      push_entry.pre_rend   = 1'b0;

      if (csr_valid) begin
         delim_in = csr_delimiter_char;
      end

      if (accept && req_func) begin
         push                = 1'b1;
         push_entry.kind     = KIND_DOC;
         push_entry.pre_rend = !err_ff && ((len_ff != '0) || fb_ff || rhf_ff);
         iq_in   = 1'b0;
         qp_in   = 1'b0;
         crp_in  = 1'b0;
         fb_in   = 1'b0;
         rhf_in  = 1'b0;
         len_in  = '0;
         fcnt_in = '0;
         rcnt_in = '0;
         err_in  = 1'b0;
      end else if (accept && !err_ff) begin
         crp_in = 1'b0;
         if (!swallow && qp_ff) begin
            qp_in = 1'b0;
            if (!is_q) begin
               iq_in = 1'b0;
            end
         end else if (!swallow && iq_ff && is_q) begin
            qp_in = 1'b1;
         end

         if (u_quote) begin
            iq_in = 1'b1;
            fb_in = 1'b1;
         end

         if (u_delim) begin
            push            = 1'b1;
            push_entry.kind = KIND_FEND;
            if (fcnt_ff != FPOS_MAX) begin
               fcnt_in = fcnt_ff + 1'b1;
            end
            len_in = '0;
            fb_in  = 1'b0;
            rhf_in = 1'b1;
         end

         if (u_nl) begin
            push            = 1'b1;
            push_entry.kind = KIND_REND;
            fcnt_in = '0;
            if (rcnt_ff != RPOS_MAX) begin
               rcnt_in = rcnt_ff + 1'b1;
            end
            len_in = '0;
            fb_in  = 1'b0;
            rhf_in = 1'b0;
            crp_in = (req_text_byte == CHAR_CR);
         end

         if (u_emit) begin
            fb_in = 1'b1;
         end

         if (emit) begin
            push = 1'b1;
            if (ovf) begin
               push_entry.kind = KIND_OVF;
               err_in          = 1'b1;
            end else begin
               push_entry.kind       = KIND_BYTE;
               push_entry.field_byte = req_text_byte;
               len_in                = len_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         iq_ff    <= 1'b0;
         qp_ff    <= 1'b0;
         crp_ff   <= 1'b0;
         fb_ff    <= 1'b0;
         rhf_ff   <= 1'b0;
         len_ff   <= '0;
         fcnt_ff  <= '0;
         rcnt_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         delim_ff <= delim_in;
         iq_ff    <= iq_in;
         qp_ff    <= qp_in;
         crp_ff   <= crp_in;
         fb_ff    <= fb_in;
         rhf_ff   <= rhf_in;
         len_ff   <= len_in;
         fcnt_ff  <= fcnt_in;
         rcnt_ff  <= rcnt_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: rtl/cst_queue.sv
// Short result queue between front end and back end.
module cst_queue import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    pop_entry,
   output q_status_type q_status
);

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_entry = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: rtl/cst_back.sv
// Back end: expands queued results and drives the result register.
module cst_back import cst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  q_status_type      q_status,
   input  entry_type         pop_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_field_byte,
   output logic [FPOS_W-1:0] rsp_field_position,
   output logic [RPOS_W-1:0] rsp_row_position,
   output logic              rsp_last_of_run
);

   logic              vld_ff, vld_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic [FPOS_W-1:0] fpos_ff, fpos_in;
   logic [RPOS_W-1:0] rpos_ff, rpos_in;
   logic              last_ff, last_in;
   logic              ph2_ff, ph2_in;
   logic [RPOS_W-1:0] drpos_ff, drpos_in;
   logic              load_ok;

   assign load_ok = !vld_ff || !rsp_stall;
   assign pop     = load_ok && !ph2_ff && !q_status.empty;

   always_comb begin
      vld_in   = vld_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      fpos_in  = fpos_ff;
      rpos_in  = rpos_ff;
      last_in  = last_ff;
      ph2_in   = ph2_ff;
      drpos_in = drpos_ff;
      if (load_ok) begin
         priority if (ph2_ff) begin
            vld_in  = 1'b1;
            kind_in = KIND_DOC;
            byte_in = 8'd0;
            fpos_in = '0;
            rpos_in = drpos_ff;
            last_in = 1'b1;
            ph2_in  = 1'b0;
         end else if (!q_status.empty) begin
            vld_in  = 1'b1;
            byte_in = pop_entry.field_byte;
            rpos_in = pop_entry.rpos;
            if (pop_entry.kind == KIND_DOC && pop_entry.pre_rend) begin
               // row end first, then document end (from ph2_ff) with the bumped row count
               kind_in  = KIND_REND;
               fpos_in  = pop_entry.fpos;
               last_in  = 1'b0;
               ph2_in   = 1'b1;
               drpos_in = (pop_entry.rpos != RPOS_MAX) ? pop_entry.rpos + 1'b1
                                                       : pop_entry.rpos;
            end else begin
               kind_in = pop_entry.kind;
               fpos_in = (pop_entry.kind == KIND_DOC) ? '0 : pop_entry.fpos;
               last_in = 1'b1;
            end
         end else begin
            vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         ph2_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         ph2_ff <= ph2_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      fpos_ff  <= fpos_in;
      rpos_ff  <= rpos_in;
      last_ff  <= last_in;
      drpos_ff <= drpos_in;
   end

   assign rsp_valid          = vld_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_field_byte     = byte_ff;
   assign rsp_field_position = fpos_ff;
   assign rsp_row_position   = rpos_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

// File: rtl/csv_stream_tokenizer.sv
// A result is written into a queue slot, then into the output register, from which it is shown.
// Throughput: one input item per cycle; the front end stalls only on a full 4-entry queue.
// An end of document closing an open row gives two results: a row end, then a document end.
// Bytes that cause no result (skipped whitespace, quotes, swallowed LF) are still accepted as input items.
// Reset (synchronous, active high) clears parser state and queue; delimiter returns to comma.
module csv_stream_tokenizer import cst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [7:0]        req_text_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_field_byte,
   output logic [FPOS_W-1:0] rsp_field_position,
   output logic [RPOS_W-1:0] rsp_row_position,
   output logic              rsp_last_of_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_delimiter_char
);

   // front end to queue
   logic         push;
   entry_type    push_entry;
   // queue to back end
   logic         pop;
   entry_type    pop_entry;
   q_status_type q_status;

   // delimiter writes are always taken; the user must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // front: byte classification, quote/CR tracking, field and row counters
   cst_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_text_byte      (req_text_byte),
      .csr_valid          (csr_valid),
      .csr_delimiter_char (csr_delimiter_char),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   // queue decouples input stalls from output stalls
   cst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // back: splits a document end into row end plus document end, holds output register
   cst_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_field_byte     (rsp_field_byte),
      .rsp_field_position (rsp_field_position),
      .rsp_row_position   (rsp_row_position),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// File: rtl/cst_checker.sv
// Checker: port-level assertions for the tokenizer, with its bind.
module cst_checker import cst_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_kind,
   input logic [7:0]        rsp_field_byte,
   input logic [FPOS_W-1:0] rsp_field_position,
   input logic [RPOS_W-1:0] rsp_row_position,
   input logic              rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_field_byte) && $stable(rsp_field_position) &&
      $stable(rsp_row_position) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_doc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DOC |-> rsp_last_of_run && rsp_field_position == '0)
      else $error("document end not last or has field position");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_field_byte == 8'd0)
      else $error("field byte set on non-byte result");

   a_rend_then_doc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_REND && !rsp_last_of_run
      |=> rsp_valid && rsp_kind == KIND_DOC)
      else $error("split row end not followed by document end");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (.*);

// File: tb/sv/tb_csv_stream_tokenizer.sv
// Self-checking testbench for the CSV stream tokenizer: directed documents, random CSV, idling.
module tb_csv_stream_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;
   import cst_pkg::*;

   // One byte or end-of-document item on its way to the block.
   typedef struct packed {
      logic       func;
      logic [7:0] text;
   } text_item_type;

   // One predicted output token.
   typedef struct {
      kind_type          kind;
      logic [7:0]        fbyte;
      logic [FPOS_W-1:0] fpos;
      logic [RPOS_W-1:0] rpos;
      logic              last;
   } token_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic [7:0]        req_text_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_kind;
   logic [7:0]        rsp_field_byte;
   logic [FPOS_W-1:0] rsp_field_position;
   logic [RPOS_W-1:0] rsp_row_position;
   logic              rsp_last_of_run;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_delimiter_char = DELIM_RESET;

   // Set for one random phase: neither side idles while it is high.
   logic calm = 1'b0;

   text_item_type text_q[$];
   text_item_type next_item;
   token_type     predicted_tokens[$];
   token_type     want;
   int            items_queued = 0;
   int            items_taken = 0;
   int            errors = 0;

   logic [7:0] blanks[4] = '{CHAR_SP, CHAR_HT, CHAR_VT, CHAR_FF};

   // Tokenizer state as the block should hold it.
   logic [7:0]        delim_now  = DELIM_RESET;
   logic              in_quote   = 1'b0;
   logic              quote_seen = 1'b0;  // quote inside quotes, next byte decides
   logic              cr_seen    = 1'b0;  // row ended on CR, one LF to swallow
   logic              field_open = 1'b0;
   logic              row_open   = 1'b0;
   int                field_len  = 0;
   logic [FPOS_W-1:0] field_idx  = '0;
   logic [RPOS_W-1:0] row_idx    = '0;
   logic              overflowed = 1'b0;

   csv_stream_tokenizer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_field_byte     (rsp_field_byte),
      .rsp_field_position (rsp_field_position),
      .rsp_row_position   (rsp_row_position),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_delimiter_char (csr_delimiter_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function void add_token(kind_type k, logic [7:0] b, logic [FPOS_W-1:0] fp,
                           logic [RPOS_W-1:0] rp);
      token_type t;
      t.kind  = k;
      t.fbyte = b;
      t.fpos  = fp;
      t.rpos  = rp;
      t.last  = 1'b0;
      predicted_tokens.push_back(t);
   endfunction

   // Content byte, or the overflow token once the field is full.
   function void push_content(logic [7:0] c);
      if (field_len >= FIELD_LIMIT - 1) begin
         overflowed = 1'b1;
         add_token(KIND_OVF, 8'h00, field_idx, row_idx);
      end else begin
         field_len++;
         add_token(KIND_BYTE, c, field_idx, row_idx);
      end
   endfunction

   function void close_row();
      add_token(KIND_REND, 8'h00, field_idx, row_idx);
      field_idx = '0;
      if (row_idx != RPOS_MAX)
         row_idx++;
      field_len  = 0;
      field_open = 1'b0;
      row_open   = 1'b0;
   endfunction

   // Byte outside quotes. Quote beats delimiter; delimiter beats CR/LF and blanks.
   function void plain_char(logic [7:0] c);
      if (c == CHAR_QUOTE) begin
         in_quote   = 1'b1;
         field_open = 1'b1;
      end else if (c == delim_now) begin
         add_token(KIND_FEND, 8'h00, field_idx, row_idx);
         if (field_idx != FPOS_MAX)
            field_idx++;
         field_len  = 0;
         field_open = 1'b0;
         row_open   = 1'b1;
      end else if (c == CHAR_LF || c == CHAR_CR) begin
         close_row();
         cr_seen = (c == CHAR_CR);
      end else if ((c == CHAR_SP || c == CHAR_HT || c == CHAR_VT || c == CHAR_FF)
                   && !field_open) begin
         // blank before the field starts: dropped
      end else begin
         field_open = 1'b1;
         push_content(c);
      end
   endfunction

   // Works out the tokens caused by one accepted item and queues them.
   function void tokenize(logic func, logic [7:0] c);
      int   first;
      logic swallow;
      first = predicted_tokens.size();
      if (func) begin
         if (!overflowed && (field_len > 0 || field_open || row_open))
            close_row();
         add_token(KIND_DOC, 8'h00, '0, row_idx);
         in_quote   = 1'b0;
         quote_seen = 1'b0;
         cr_seen    = 1'b0;
         field_open = 1'b0;
         row_open   = 1'b0;
         field_len  = 0;
         field_idx  = '0;
         row_idx    = '0;
         overflowed = 1'b0;
      end else if (!overflowed) begin
         swallow = 1'b0;
         if (cr_seen) begin
            cr_seen = 1'b0;
            swallow = (c == CHAR_LF);
         end
         if (!swallow) begin
            if (quote_seen) begin
               quote_seen = 1'b0;
               if (c == CHAR_QUOTE) begin
                  push_content(c);
               end else begin
                  in_quote = 1'b0;
                  plain_char(c);
               end
            end else if (in_quote) begin
               if (c == CHAR_QUOTE)
                  quote_seen = 1'b1;
               else
                  push_content(c);
            end else begin
               plain_char(c);
            end
         end
      end
      if (predicted_tokens.size() > first)
         predicted_tokens[predicted_tokens.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- driver
   // A transfer is seen on the old port values at the edge; the next item is
   // then loaded with nonblocking writes, each signal written once per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            tokenize(req_func, req_text_byte);
            items_taken <= items_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (text_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
               next_item = text_q.pop_front();
               req_valid     <= 1'b1;
               req_func      <= next_item.func;
               req_text_byte <= next_item.text;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function void check_field(string what, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
                  act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_tokens.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual kind %0d byte %0d",
                        $time, rsp_kind, rsp_field_byte);
               errors++;
            end else begin
               want = predicted_tokens.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("field_byte", want.fbyte, rsp_field_byte);
               check_field("field_position", want.fpos, rsp_field_position);
               check_field("row_position", want.rpos, rsp_row_position);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_item(logic func, logic [7:0] c);
      text_item_type it;
      it.func = func;
      it.text = c;
      text_q.push_back(it);
      items_queued++;
   endtask

   // End of document; the text byte is ignored, so it is random.
   task automatic push_doc();
      push_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_item(1'b0, s[i]);
   endtask

   // Unquoted content byte: no quote, no row end, no delimiter.
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do
         c = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(33, 126));
      while (c == CHAR_QUOTE || c == CHAR_CR || c == CHAR_LF || c == delim_now);
      return c;
   endfunction

   // Mostly well-formed CSV with random content, some stray bytes and early ends.
   task automatic gen_documents(int count);
      int         first;
      int         roll;
      int         pick;
      logic [7:0] c;
      first = items_queued;
      while (items_queued - first < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            push_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
         end else if (roll < 9) begin
            push_doc();
         end else begin
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 2)) push_item(1'b0, blanks[$urandom_range(0, 3)]);
            if ($urandom_range(0, 9) < 3) begin
               push_item(1'b0, CHAR_QUOTE);
               repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 6) == 0) begin
                     push_item(1'b0, CHAR_QUOTE);
                     push_item(1'b0, CHAR_QUOTE);
                  end else if ($urandom_range(0, 3) == 0) begin
                     pick = $urandom_range(0, 2);
                     push_item(1'b0, pick == 0 ? delim_now : pick == 1 ? CHAR_CR : CHAR_LF);
                  end else begin
                     do
                        c = 8'($urandom_range(0, 255));
                     while (c == CHAR_QUOTE);
                     push_item(1'b0, c);
                  end
               end
               push_item(1'b0, CHAR_QUOTE);
               if ($urandom_range(0, 9) == 0)
                  push_item(1'b0, plain_byte());
            end else begin
               repeat ($urandom_range(0, 6)) push_item(1'b0, plain_byte());
            end
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               push_item(1'b0, delim_now);
            end else if (roll < 95) begin
               case ($urandom_range(0, 2))
                  0: push_item(1'b0, CHAR_LF);
                  1: push_item(1'b0, CHAR_CR);
                  default: begin
                     push_item(1'b0, CHAR_CR);
                     push_item(1'b0, CHAR_LF);
                  end
               endcase
               if ($urandom_range(0, 6) == 0)
                  push_item(1'b0, CHAR_LF);
            end
         end
      end
      push_doc();
   endtask

   // Waits for every item to be taken and every token to arrive, then lets the
   // pipeline settle: bytes with no token may still be in flight.
   task automatic drain();
      int spin;
      while (items_taken != items_queued)
         @(posedge clock);
      spin = 0;
      while (predicted_tokens.size() != 0 && spin < 2000) begin
         @(posedge clock);
         spin++;
      end
      if (predicted_tokens.size() != 0) begin
         $display("%0t: %0d expected transfers never arrived", $time, predicted_tokens.size());
         errors++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Register write; only called with the block idle, right after an edge.
   task automatic set_delimiter(logic [7:0] d);
      csr_valid          <= 1'b1;
      csr_delimiter_char <= d;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      delim_now = d;
   endtask

   initial begin
      logic [7:0] rand_delims[5];
      rand_delims = '{8'h00, 8'hFF, 8'h3B, CHAR_HT, 8'h00};
      rand_delims[4] = 8'($urandom_range(0, 255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset delimiter (comma): quoted field holding comma and LF,
      // doubled quote, byte after the closing quote, CRLF, extreme bytes.
      push_text("a,\"p,\n\"\"q\" z\015\n");
      push_item(1'b0, 8'h00);
      push_text(",");
      push_item(1'b0, 8'hFF);
      push_text("\n");
      // blanks skipped before a field, CR row end, CR alone as an empty line
      push_text(" \t\013\014x\015\015");
      push_text("\"");
      push_doc();                      // unclosed quote at end
      push_text("q,");
      push_doc();                      // row open after a delimiter
      push_doc();                      // empty document
      drain();

      // Delimiter equal to quote: the quote meaning wins.
      set_delimiter(CHAR_QUOTE);
      push_text("a\"b\"\",\n");
      push_doc();
      drain();

      // Delimiter equal to CR, then to LF: the delimiter meaning wins.
      set_delimiter(CHAR_CR);
      push_text("a\015b\n\015\n");
      push_doc();
      drain();
      set_delimiter(CHAR_LF);
      push_text("a\n\015\nb");
      push_doc();
      drain();

      // Random CSV across several delimiters, extremes included.
      foreach (rand_delims[i]) begin
         set_delimiter(rand_delims[i]);
         calm <= (i == 2);
         gen_documents(125);
         drain();
      end
      calm <= 1'b0;

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
